// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// Polygon signed distance package
// Shared constants, codes and state types of the polygon distance engine.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int MaxVertices = 64;
  localparam int CoordBits   = 24;
  localparam int QueueDepth  = 4;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_READ,
    BK_DIFF,
    BK_MUL,
    BK_SUM,
    BK_SEL,
    BK_SQMUL,
    BK_NUM,
    BK_DIV,
    BK_SQRT,
    BK_NEXT,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== rtl/core/psd_fifo.sv =====
// ----------------------------------------------------------------------------
// Polygon distance command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module psd_fifo #(
  parameter int Width = 8,
  parameter int Depth = psd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);
  import psd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] buf_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/psd_front.sv =====
// ----------------------------------------------------------------------------
// Polygon distance front end
// Accepts items, tracks the vertex count and queues appends and queries.
// ----------------------------------------------------------------------------
module psd_front #(
  parameter int MaxVertices = psd_pkg::MaxVertices,
  parameter int CoordBits   = psd_pkg::CoordBits,
  parameter int EntryW      = 1 + (((MaxVertices > 1) ? $clog2(MaxVertices) : 1) + 1)
                              + 2 * CoordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psd_pkg::kind_e       kind_i,
  input  logic [CoordBits-1:0] x_i,
  input  logic [CoordBits-1:0] y_i,
  output psd_pkg::hs_t         push_o,
  input  logic                 push_ready_i,
  output logic [EntryW-1:0]    entry_o
);
  import psd_pkg::*;

  localparam int AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int NW = AW + 1;

  logic [NW-1:0] count_q, count_d;
  logic          accept, has_room, push;
  op_e           op;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign has_room   = (count_q < NW'(MaxVertices));

  always_comb begin
    count_d = count_q;
    push    = 1'b0;
    op      = OP_APPEND;
    unique case (kind_i)
      KIND_CLEAR: begin
        if (accept) count_d = '0;
      end
      KIND_APPEND: begin
        if (accept && has_room) begin
          push    = 1'b1;
          count_d = count_q + NW'(1);
        end
      end
      KIND_QUERY: begin
        push = accept;
        op   = OP_QUERY;
      end
      default: ;
    endcase
  end

  assign push_o.valid = push;
  assign push_o.ready = push_ready_i;
  assign entry_o      = {op, count_q, x_i, y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/core/psd_back.sv =====
// ----------------------------------------------------------------------------
// Polygon distance back end
// Holds the vertex memory and walks the edges with a shared multiplier,
// a bit-serial divider and a bit-serial square root.
// ----------------------------------------------------------------------------
module psd_back #(
  parameter int MaxVertices = psd_pkg::MaxVertices,
  parameter int CoordBits   = psd_pkg::CoordBits,
  parameter int EntryW      = 1 + (((MaxVertices > 1) ? $clog2(MaxVertices) : 1) + 1)
                              + 2 * CoordBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 entry_valid_i,
  input  logic [EntryW-1:0]    entry_i,
  output logic                 entry_pop_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [CoordBits-1:0] res_dist_o,
  output logic                 res_inside_o
);
  import psd_pkg::*;

  localparam int AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int NW = AW + 1;
  localparam int CB = CoordBits;
  localparam int DW = CB + 1;
  localparam int MW = DW + 1;
  localparam int PW = 2 * MW;
  localparam int QW = 2 * DW;
  localparam int XW = 4 * DW;
  localparam int IW = $clog2(QW + 1);
  localparam int WW = AW + 2;
  localparam int BW = CB - 1;
  localparam int KW = 4;
  localparam int MulSteps = 10;
  localparam int SqSteps  = 3;

  bk_state_e state_q, state_d;

  logic [2*CB-1:0]       mem_q [MaxVertices];
  logic [2*CB-1:0]       rda_q, rdb_q;
  logic [NW-1:0]         n_q, idx_q, idx_inc, jdx;
  logic signed [CB-1:0]  px_q, py_q, ax, ay, bx, by;
  logic signed [DW-1:0]  ex_q, ey_q, qx_q, qy_q, rx_q, ry_q;
  logic [KW-1:0]         k_q;
  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [PW-1:0]  prod_q [MulSteps];
  logic signed [PW-1:0]  dot_q, len2_q, ap2_q, bp2_q, cr_q, cr_abs;
  logic [QW-1:0]         crmag_q;
  logic [XW-1:0]         num;
  logic [QW-1:0]         rem_q, numlo_q, quo_q, op_q, res_q, one_q;
  logic [QW:0]           rem2, rem_sub, sq_t;
  logic                  div_ge, sq_ge;
  logic [IW-1:0]         cnt_q;
  logic [BW-1:0]         best_q;
  logic signed [WW-1:0]  wind_q;
  logic                  dot_pos, beyond, mid, cr_pos, cr_neg;
  logic                  out_free, out_load;
  logic                  res_valid_q, res_inside_q;
  logic [CB-1:0]         res_dist_q;
  logic                  entry_query;
  logic [NW-1:0]         entry_n;

  assign entry_query = (op_e'(entry_i[EntryW-1]) == OP_QUERY);
  assign entry_n     = entry_i[EntryW-2 -: NW];

  assign idx_inc = idx_q + NW'(1);
  assign jdx     = (idx_inc < n_q) ? idx_inc : '0;
  assign ax      = rda_q[2*CB-1:CB];
  assign ay      = rda_q[CB-1:0];
  assign bx      = rdb_q[2*CB-1:CB];
  assign by      = rdb_q[CB-1:0];

  assign dot_pos = (dot_q > 0);
  assign beyond  = (dot_q >= len2_q);
  assign mid     = dot_pos && !beyond;
  assign cr_neg  = cr_q[PW-1];
  assign cr_pos  = !cr_neg && (cr_q != '0);
  assign cr_abs  = cr_neg ? -cr_q : cr_q;

  assign num = (XW'(prod_q[0][QW-1:0]) << QW) + (XW'(prod_q[1][QW-1:0]) << (DW + 1))
             + XW'(prod_q[2][QW-1:0]);

  assign rem2    = {rem_q, numlo_q[QW-1]};
  assign div_ge  = (rem2 >= {1'b0, len2_q[QW-1:0]});
  assign rem_sub = rem2 - {1'b0, len2_q[QW-1:0]};
  assign sq_t    = {1'b0, res_q} + {1'b0, one_q};
  assign sq_ge   = ({1'b0, op_q} >= sq_t);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == BK_SQMUL) begin
      case (k_q)
        KW'(0): begin
          mul_a = $signed({1'b0, crmag_q[QW-1:DW]});
          mul_b = $signed({1'b0, crmag_q[QW-1:DW]});
        end
        KW'(1): begin
          mul_a = $signed({1'b0, crmag_q[QW-1:DW]});
          mul_b = $signed({1'b0, crmag_q[DW-1:0]});
        end
        default: begin
          mul_a = $signed({1'b0, crmag_q[DW-1:0]});
          mul_b = $signed({1'b0, crmag_q[DW-1:0]});
        end
      endcase
    end else begin
      case (k_q)
        KW'(0): begin mul_a = MW'(ex_q); mul_b = MW'(qx_q); end
        KW'(1): begin mul_a = MW'(ey_q); mul_b = MW'(qy_q); end
        KW'(2): begin mul_a = MW'(ex_q); mul_b = MW'(ex_q); end
        KW'(3): begin mul_a = MW'(ey_q); mul_b = MW'(ey_q); end
        KW'(4): begin mul_a = MW'(qx_q); mul_b = MW'(qx_q); end
        KW'(5): begin mul_a = MW'(qy_q); mul_b = MW'(qy_q); end
        KW'(6): begin mul_a = MW'(rx_q); mul_b = MW'(rx_q); end
        KW'(7): begin mul_a = MW'(ry_q); mul_b = MW'(ry_q); end
        KW'(8): begin mul_a = MW'(ex_q); mul_b = MW'(qy_q); end
        default: begin mul_a = MW'(ey_q); mul_b = MW'(qx_q); end
      endcase
    end
  end

  assign out_free = !res_valid_q || res_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (entry_valid_i && entry_query) begin
          state_d = (entry_n == '0) ? BK_EMIT : BK_READ;
        end
      end
      BK_READ:  state_d = BK_DIFF;
      BK_DIFF:  state_d = BK_MUL;
      BK_MUL:   if (k_q == KW'(MulSteps - 1)) state_d = BK_SUM;
      BK_SUM:   state_d = BK_SEL;
      BK_SEL:   state_d = mid ? BK_SQMUL : BK_SQRT;
      BK_SQMUL: if (k_q == KW'(SqSteps - 1)) state_d = BK_NUM;
      BK_NUM:   state_d = BK_DIV;
      BK_DIV:   if (cnt_q == IW'(QW - 1)) state_d = BK_SQRT;
      BK_SQRT:  if (cnt_q == IW'(DW - 1)) state_d = BK_NEXT;
      BK_NEXT:  state_d = (idx_inc == n_q) ? BK_EMIT : BK_READ;
      BK_EMIT:  if (out_free) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    entry_pop_o = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      BK_IDLE: entry_pop_o = entry_valid_i;
      BK_EMIT: out_load    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_pop_o && !entry_query) begin
      mem_q[entry_n[AW-1:0]] <= entry_i[2*CB-1:0];
    end
    if (state_q == BK_READ) begin
      rda_q <= mem_q[idx_q[AW-1:0]];
      rdb_q <= mem_q[jdx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_dist_q   <= (wind_q != '0) ? -CB'(best_q) : CB'(best_q);
      res_inside_q <= (wind_q != '0);
    end
    case (state_q)
      BK_IDLE: begin
        if (entry_pop_o && entry_query) begin
          n_q    <= entry_n;
          idx_q  <= '0;
          px_q   <= entry_i[2*CB-1:CB];
          py_q   <= entry_i[CB-1:0];
          best_q <= '1;
          wind_q <= '0;
        end
      end
      BK_READ: k_q <= '0;
      BK_DIFF: begin
        ex_q <= DW'(bx) - DW'(ax);
        ey_q <= DW'(by) - DW'(ay);
        qx_q <= DW'(px_q) - DW'(ax);
        qy_q <= DW'(py_q) - DW'(ay);
        rx_q <= DW'(px_q) - DW'(bx);
        ry_q <= DW'(py_q) - DW'(by);
      end
      BK_MUL, BK_SQMUL: begin
        prod_q[k_q] <= mul_a * mul_b;
        k_q         <= k_q + KW'(1);
      end
      BK_SUM: begin
        dot_q  <= prod_q[0] + prod_q[1];
        len2_q <= prod_q[2] + prod_q[3];
        ap2_q  <= prod_q[4] + prod_q[5];
        bp2_q  <= prod_q[6] + prod_q[7];
        cr_q   <= prod_q[8] - prod_q[9];
      end
      BK_SEL: begin
        if (ay <= py_q) begin
          if (by > py_q && cr_pos) wind_q <= wind_q + WW'(1);
        end else begin
          if (by <= py_q && cr_neg) wind_q <= wind_q - WW'(1);
        end
        k_q     <= '0;
        crmag_q <= cr_abs[QW-1:0];
        op_q    <= dot_pos ? bp2_q[QW-1:0] : ap2_q[QW-1:0];
        res_q   <= '0;
        one_q   <= QW'(1) << (QW - 2);
        cnt_q   <= '0;
      end
      BK_NUM: begin
        rem_q   <= num[XW-1:QW];
        numlo_q <= num[QW-1:0];
        quo_q   <= '0;
        cnt_q   <= '0;
      end
      BK_DIV: begin
        rem_q   <= div_ge ? rem_sub[QW-1:0] : rem2[QW-1:0];
        numlo_q <= numlo_q << 1;
        quo_q   <= {quo_q[QW-2:0], div_ge};
        cnt_q   <= (cnt_q == IW'(QW - 1)) ? '0 : cnt_q + IW'(1);
        if (cnt_q == IW'(QW - 1)) begin
          op_q  <= {quo_q[QW-2:0], div_ge};
          res_q <= '0;
          one_q <= QW'(1) << (QW - 2);
        end
      end
      BK_SQRT: begin
        if (sq_ge) begin
          op_q  <= op_q - sq_t[QW-1:0];
          res_q <= (res_q >> 1) + one_q;
        end else begin
          res_q <= res_q >> 1;
        end
        one_q <= one_q >> 2;
        cnt_q <= cnt_q + IW'(1);
      end
      BK_NEXT: begin
        if (res_q < QW'(best_q)) best_q <= res_q[BW-1:0];
        idx_q <= idx_inc;
      end
      default: ;
    endcase
  end

  assign res_valid_o  = res_valid_q;
  assign res_dist_o   = res_dist_q;
  assign res_inside_o = res_inside_q;

endmodule

// ===== rtl/core/polygon_signed_distance_top.sv =====
// ----------------------------------------------------------------------------
// Polygon signed distance
// Clear takes effect at acceptance; an append is written when the back end takes it.
// A query walks every edge with the shared multiplier and a square root; an edge
// whose nearest point lies between its ends also takes a division (24-bit
// coordinates); the divider and the square root work one bit per cycle.
// One query is worked at a time; the queue and result register keep input open.
// Reset: vertex count zero, queue and result empty, vertex memory not cleared.
// ----------------------------------------------------------------------------
module polygon_signed_distance_top #(
  parameter int MAX_VERTICES = psd_pkg::MaxVertices,
  parameter int COORD_BITS   = psd_pkg::CoordBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata, // x_coord, y_coord
  input  logic [1:0]                            s_axis_tuser, // kind
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((COORD_BITS+7)/8)*8-1:0]       m_axis_tdata, // signed_distance
  output logic                                  m_axis_tuser  // inside_res
);
  import psd_pkg::*;

  localparam int AW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EntryW = 1 + (AW + 1) + 2 * COORD_BITS;
  localparam int ODW    = ((COORD_BITS + 7) / 8) * 8;

  hs_t                   push;
  logic                  q_ready, q_valid, q_pop;
  logic [EntryW-1:0]     push_entry, q_entry;
  logic [COORD_BITS-1:0] res_dist;

  psd_front #(
    .MaxVertices(MAX_VERTICES),
    .CoordBits  (COORD_BITS),
    .EntryW     (EntryW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (kind_e'(s_axis_tuser)),
    .x_i         (s_axis_tdata[COORD_BITS-1:0]),
    .y_i         (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .push_o      (push),
    .push_ready_i(q_ready),
    .entry_o     (push_entry)
  );

  psd_fifo #(
    .Width(EntryW),
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push.valid),
    .data_i (push_entry),
    .ready_o(q_ready),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_entry)
  );

  psd_back #(
    .MaxVertices(MAX_VERTICES),
    .CoordBits  (COORD_BITS),
    .EntryW     (EntryW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_valid_i(q_valid),
    .entry_i      (q_entry),
    .entry_pop_o  (q_pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_dist_o   (res_dist),
    .res_inside_o (m_axis_tuser)
  );

  assign m_axis_tdata = ODW'(res_dist);

  a_inside_neg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> $signed(res_dist) <= 0)
    else $error("inside result with positive distance");

  a_outside_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> !res_dist[COORD_BITS-1])
    else $error("outside result with negative distance");

  a_queue_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> push.ready)
    else $error("queue push while full");

endmodule

// ===== bench/polygon_signed_distance_top_tb.sv =====
// ----------------------------------------------------------------------------
// Polygon signed distance testbench
// Builds polygons from append transactions and checks every query result
// against an exact integer predictor of the edge distance and winding test.
// A directed table covers the empty polygon, one vertex, zero-length edges,
// coordinate extremes, saturation and ignored kinds. Random polygons with
// random query points follow, with random idling on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polygon_signed_distance_top_tb;
  import psd_pkg::*;

  localparam int NV = MaxVertices;
  localparam int CB = CoordBits;
  localparam logic [CB-1:0] DIST_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam int N_RANDOM = 1750;

  typedef logic signed [127:0] wide_t;
  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    logic [CB-1:0] dist_val;
    logic          in_poly;
  } answer_t;

  typedef struct {
    kind_e   kind;
    coord_t  x;
    coord_t  y;
    logic    typed;
    answer_t ans;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [2*CB-1:0]     s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [CB-1:0]       m_axis_tdata;
  logic                m_axis_tuser;

  polygon_signed_distance_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),  // x_coord, y_coord
    .s_axis_tuser (s_axis_tuser),  // kind
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),  // signed_distance
    .m_axis_tuser (m_axis_tuser)   // inside_res
  );

  longint      poly_x[NV];
  longint      poly_y[NV];
  int unsigned poly_count;
  answer_t     pending_answers[$];
  int          fail_count;
  bit          calm;
  bit          stim_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #600ms;
    $display("Test completed with failures");
    $finish;
  end

  // Largest d with d*d*den <= num.
  function automatic wide_t root_ratio(wide_t num, wide_t den);
    wide_t d;
    wide_t c;
    d = 0;
    for (int b = 33; b >= 0; b--) begin
      c = d | (wide_t'(1) << b);
      if (c * c * den <= num) d = c;
    end
    return d;
  endfunction

  function automatic wide_t seg_distance(longint ax, longint ay, longint bx, longint by,
                                         longint px, longint py);
    wide_t ex, ey, qx, qy, rx, ry, dot, len2, ap2;
    ex = bx - ax; ey = by - ay;
    qx = px - ax; qy = py - ay;
    rx = px - bx; ry = py - by;
    dot  = ex * qx + ey * qy;
    len2 = ex * ex + ey * ey;
    ap2  = qx * qx + qy * qy;
    if (dot <= 0) return root_ratio(ap2, 1);
    if (dot >= len2) return root_ratio(rx * rx + ry * ry, 1);
    return root_ratio(ap2 * len2 - dot * dot, len2);
  endfunction

  function automatic answer_t query_answer(longint px, longint py);
    wide_t   best, d, cr;
    longint  ax, ay, bx, by;
    int      wind;
    int      j;
    answer_t a;
    best = DIST_MAX;
    wind = 0;
    for (int i = 0; i < poly_count; i++) begin
      j  = (i + 1 < poly_count) ? i + 1 : 0;
      ax = poly_x[i]; ay = poly_y[i];
      bx = poly_x[j]; by = poly_y[j];
      d  = seg_distance(ax, ay, bx, by, px, py);
      cr = wide_t'(bx - ax) * wide_t'(py - ay) - wide_t'(by - ay) * wide_t'(px - ax);
      if (d < best) best = d;
      if (ay <= py) begin
        if (by > py && cr > 0) wind++;
      end else begin
        if (by <= py && cr < 0) wind--;
      end
    end
    a.dist_val = (wind != 0) ? CB'(-best) : CB'(best);
    a.in_poly  = (wind != 0);
    return a;
  endfunction

  // Update the polygon copy; return 1 when a result is due.
  function automatic bit apply_item(kind_e kind, coord_t x, coord_t y, output answer_t a);
    longint px, py;
    px = longint'($signed(x));
    py = longint'($signed(y));
    a  = '0;
    case (kind)
      KIND_CLEAR: begin
        poly_count = 0;
      end
      KIND_APPEND: begin
        if (poly_count < NV) begin
          poly_x[poly_count] = px;
          poly_y[poly_count] = py;
          poly_count++;
        end
      end
      KIND_QUERY: begin
        a = query_answer(px, py);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send(kind_e kind, coord_t x, coord_t y, bit typed = 0,
                      answer_t typed_ans = '0);
    answer_t a;
    int      gap;
    gap = draw_wait();
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (apply_item(kind, x, y, a)) begin
      if (typed && a != typed_ans)
        $error("table row disagrees with predictor: %h vs %h", typed_ans, a);
      pending_answers.insert(pending_answers.size(), typed ? typed_ans : a);
    end
  endtask

  function automatic coord_t near(longint c, longint span);
    longint off;
    off = longint'($urandom_range(0, 2 * span)) - span;
    return coord_t'(c + off);
  endfunction

  // Receive side: draw a stall per transaction and check each result.
  initial begin
    answer_t want;
    int      stall;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if (pending_answers.size() == 0) begin
        $error("unexpected result transaction: dist %h inside %b", m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata !== want.dist_val) begin
          $error("signed_distance: expected %h, actual %h", want.dist_val, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser !== want.in_poly) begin
          $error("inside_res: expected %b, actual %b", want.in_poly, m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    row_t   rows[25];
    int     sent;
    int     nv, nq, scale;
    longint cx, cy;
    coord_t rx, ry;
    fail_count    = 0;
    calm          = 1'b0;
    poly_count    = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_NONE;
    rst_ni        = 1'b0;

    rows = '{
      '{KIND_QUERY,  24'h000000, 24'h000000, 1, '{DIST_MAX, 1'b0}},
      '{KIND_NONE,   24'h000005, 24'h000005, 0, '0},
      '{KIND_QUERY,  24'h800000, 24'h7fffff, 1, '{DIST_MAX, 1'b0}},
      '{KIND_APPEND, 24'h000000, 24'h000000, 0, '0},
      '{KIND_QUERY,  24'h000000, 24'h000000, 1, '{24'h0, 1'b0}},
      '{KIND_QUERY,  24'd300,    24'd400,    0, '0},
      '{KIND_CLEAR,  24'hffffff, 24'hffffff, 0, '0},
      '{KIND_APPEND, 24'h800000, 24'h800000, 0, '0},
      '{KIND_QUERY,  24'h7fffff, 24'h7fffff, 1, '{DIST_MAX, 1'b0}},
      '{KIND_APPEND, 24'h800000, 24'h800000, 0, '0},
      '{KIND_APPEND, 24'h7fffff, 24'h800000, 0, '0},
      '{KIND_APPEND, 24'h7fffff, 24'h7fffff, 0, '0},
      '{KIND_APPEND, 24'h800000, 24'h7fffff, 0, '0},
      '{KIND_QUERY,  24'h000000, 24'h000000, 0, '0},
      '{KIND_QUERY,  24'h7fffff, 24'h000000, 0, '0},
      '{KIND_CLEAR,  24'h000000, 24'h000000, 0, '0},
      '{KIND_APPEND, 24'h000000, 24'h000000, 0, '0},
      '{KIND_APPEND, 24'd2560,   24'h000000, 0, '0},
      '{KIND_APPEND, 24'd2560,   24'd2560,   0, '0},
      '{KIND_APPEND, 24'h000000, 24'd2560,   0, '0},
      '{KIND_QUERY,  24'd1280,   24'd1280,   0, '0},
      '{KIND_QUERY,  24'd1280,   24'hffff00, 0, '0},
      '{KIND_QUERY,  24'd3000,   24'd3000,   0, '0},
      '{KIND_NONE,   24'h123456, 24'hedcba9, 0, '0},
      '{KIND_QUERY,  24'd2560,   24'd1280,   0, '0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].kind, rows[i].x, rows[i].y, rows[i].typed, rows[i].ans);

    sent = 0;
    while (sent < N_RANDOM) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      if (sent > N_RANDOM / 2 && sent < N_RANDOM / 2 + 20) begin
        // hold off until every outstanding query has answered
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 6) != 0) begin
        case ($urandom_range(0, 3))
          0:       scale = 1 << 8;
          1:       scale = 1 << 12;
          2:       scale = 1 << 16;
          default: scale = 1 << 23;
        endcase
        cx = longint'($signed(coord_t'($urandom)));
        cy = longint'($signed(coord_t'($urandom)));
        if (scale < (1 << 23)) begin
          cx = cx >>> 2;
          cy = cy >>> 2;
        end
        nv = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
        nq = (nv > 16) ? 2 : $urandom_range(1, 6);
        send(KIND_CLEAR, coord_t'($urandom), coord_t'($urandom));
        sent++;
        for (int k = 0; k < nv; k++) begin
          send(KIND_APPEND, near(cx, scale), near(cy, scale));
          sent++;
        end
        for (int k = 0; k < nq; k++) begin
          send(KIND_QUERY, near(cx, scale + scale / 2), near(cy, scale + scale / 2));
          sent++;
        end
      end else begin
        rx = coord_t'($urandom);
        ry = coord_t'($urandom);
        case ($urandom_range(0, 3))
          0: send(KIND_APPEND, rx, ry);
          1: send(KIND_QUERY, rx, ry);
          2: send(KIND_NONE, rx, ry);
          default: send(KIND_CLEAR, rx, ry);
        endcase
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= KIND_NONE;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (8000) @(posedge clk_i);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/psd_pkg.sv
rtl/core/psd_fifo.sv
rtl/core/psd_front.sv
rtl/core/psd_back.sv
rtl/core/polygon_signed_distance_top.sv
bench/polygon_signed_distance_top_tb.sv
